// ----- hw/rtl/smsd_pkg.sv -----
// ----------------------------------------------------------------------------
// smsd_pkg: shared types and constants
// Field widths of the sample and result channels, the window length register
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smsd_pkg;

  // Channel field widths
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned MEDD_W    = 9;
  localparam int unsigned COUNT_W   = 32;

  // Window length register
  localparam int unsigned LEN_REG_W = 11;
  localparam logic [LEN_REG_W-1:0] LEN_RESET = 11'd32;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // latch sample and window-full flag
    logic load_old;   // latch oldest ring sample
    logic srch_go;    // start a rank search over the count tree
    logic srch_lo;    // search for the lower middle rank
    logic upd_go;     // start a count update walk
    logic upd_dec;    // update walk removes the oldest sample
    logic clr_run;    // clear one tree node
    logic finish;     // load result, write ring, advance pointer
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;       // window was full when the sample arrived
    logic even;       // effective window length is even
    logic srch_last;  // search takes its final decision this cycle
    logic upd_busy;   // update walk still reading or writing
    logic clr_last;   // clearing pass at its final node
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/smsd_sample_if.sv -----
// ----------------------------------------------------------------------------
// smsd_sample_if: sample channel
// Valid/ready channel carrying one unsigned sample per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface smsd_sample_if;
  logic                          valid;
  logic                          ready;
  logic [smsd_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/smsd_result_if.sv -----
// ----------------------------------------------------------------------------
// smsd_result_if: result channel
// Valid/ready channel carrying the spike test result of one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface smsd_result_if;
  logic                         valid;
  logic                         ready;
  logic                         window_full;
  logic                         spike;
  logic [smsd_pkg::MEDD_W-1:0]  median_doubled;
  logic [smsd_pkg::COUNT_W-1:0] spike_count;

  modport source (output valid, output window_full, output spike,
                  output median_doubled, output spike_count, input ready);
  modport sink (input valid, input window_full, input spike,
                input median_doubled, input spike_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/smsd_ram.sv -----
// ----------------------------------------------------------------------------
// smsd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/smsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// smsd_ctrl: sequencing controller
// Steps each sample through median searches, count tree updates and the
// result load; runs the clearing pass after reset and length writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smsd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire smsd_pkg::sts_t sts_i,
  output smsd_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_LOAD    = 4'd2;
  localparam logic [3:0] ST_SRCH_HI = 4'd3;
  localparam logic [3:0] ST_LO_GO   = 4'd4;
  localparam logic [3:0] ST_SRCH_LO = 4'd5;
  localparam logic [3:0] ST_DEC_GO  = 4'd6;
  localparam logic [3:0] ST_DEC     = 4'd7;
  localparam logic [3:0] ST_INC_GO  = 4'd8;
  localparam logic [3:0] ST_INC     = 4'd9;
  localparam logic [3:0] ST_FIN     = 4'd10;

  logic [3:0] state_q, state_d;

  // Take a sample only when idle and no length write is under way
  assign in_ready_o = (state_q == ST_IDLE) && !cfg_we_i;

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_run = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && !cfg_we_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load_old = 1'b1;
        if (sts_i.full) begin
          cmd_o.srch_go = 1'b1;
          state_d       = ST_SRCH_HI;
        end else begin
          cmd_o.upd_go = 1'b1;
          state_d      = ST_INC;
        end
      end
      ST_SRCH_HI: begin
        if (sts_i.srch_last) begin
          state_d = sts_i.even ? ST_LO_GO : ST_DEC_GO;
        end
      end
      ST_LO_GO: begin
        cmd_o.srch_go = 1'b1;
        cmd_o.srch_lo = 1'b1;
        state_d       = ST_SRCH_LO;
      end
      ST_SRCH_LO: begin
        if (sts_i.srch_last) begin
          state_d = ST_DEC_GO;
        end
      end
      ST_DEC_GO: begin
        cmd_o.upd_go  = 1'b1;
        cmd_o.upd_dec = 1'b1;
        state_d       = ST_DEC;
      end
      ST_DEC: begin
        if (!sts_i.upd_busy) begin
          state_d = ST_INC_GO;
        end
      end
      ST_INC_GO: begin
        cmd_o.upd_go = 1'b1;
        state_d      = ST_INC;
      end
      ST_INC: begin
        if (!sts_i.upd_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    // A length write empties the window and restarts the clearing pass
    if (cfg_we_i) begin
      state_d = ST_CLEAR;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/smsd_dp.sv -----
// ----------------------------------------------------------------------------
// smsd_dp: datapath
// Count tree over sample values (leaves form the histogram), sample ring,
// rank search and update walks, spike counter and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smsd_dp #(
  parameter int unsigned VALUE_BITS = 8,
  parameter int unsigned WINDOW_MAX = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [smsd_pkg::LEN_REG_W-1:0]     cfg_len_i,
  input  wire logic [smsd_pkg::SAMPLE_W-1:0]      sample_i,
  input  wire smsd_pkg::cmd_t                     cmd_i,
  output smsd_pkg::sts_t                          sts_o,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic                                    window_full_o,
  output logic                                    spike_o,
  output logic [smsd_pkg::MEDD_W-1:0]             median_doubled_o,
  output logic [smsd_pkg::COUNT_W-1:0]            spike_count_o
);

  localparam int unsigned NODE_AW    = VALUE_BITS + 1;
  localparam int unsigned TREE_DEPTH = 2 ** NODE_AW;
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int unsigned RING_AW    = $clog2(WINDOW_MAX);
  localparam int unsigned LVL_W      = $clog2(VALUE_BITS + 1);

  // Configuration and window control
  logic [smsd_pkg::LEN_REG_W-1:0] len_reg_q;
  logic [31:0]                    len_wide;
  logic [CNT_W-1:0]               eff_len;
  logic [CNT_W-1:0]               rank_hi, rank_lo;
  logic [RING_AW-1:0]             ptr_q;
  logic [CNT_W-1:0]               ptr_inc;
  logic [CNT_W-1:0]               held_q;
  logic [smsd_pkg::COUNT_W-1:0]   total_q, total_d;

  // Item payload
  logic [VALUE_BITS-1:0] sample_q, old_q, m1_q, m2_q;
  logic                  full_q;
  logic [VALUE_BITS:0]   medd_val;
  logic                  spike_now;

  // Search walk
  logic                  srch_act_q, srch_lo_q;
  logic [LVL_W-1:0]      srch_lvl_q;
  logic [NODE_AW-1:0]    node_q, node_d;
  logic [CNT_W-1:0]      rank_q, rank_d;
  logic                  go_right;

  // Update walk
  logic                  upd_act_q, upd_dec_q, wr_pend_q;
  logic [LVL_W-1:0]      upd_lvl_q, upd_shift;
  logic [VALUE_BITS-1:0] upd_val_q;
  logic [NODE_AW-1:0]    path_idx, wr_addr_q;

  // Clearing pass
  logic [NODE_AW-1:0]    clr_q;

  // Memories
  logic                  tree_we;
  logic [NODE_AW-1:0]    tree_waddr, tree_raddr;
  logic [CNT_W-1:0]      tree_wdata, tree_rdata;
  logic [VALUE_BITS-1:0] ring_rdata;

  // Result register
  logic                          out_valid_q, out_full_q, out_spike_q;
  logic [smsd_pkg::MEDD_W-1:0]   out_medd_q;
  logic [smsd_pkg::COUNT_W-1:0]  out_count_q;

  // Clamp the length register to the supported window
  always_comb begin
    if (len_reg_q == '0) begin
      len_wide = 32'd1;
    end else if (32'(len_reg_q) > 32'(WINDOW_MAX)) begin
      len_wide = 32'(WINDOW_MAX);
    end else begin
      len_wide = 32'(len_reg_q);
    end
  end

  assign eff_len = len_wide[CNT_W-1:0];
  assign rank_lo = eff_len >> 1;
  assign rank_hi = rank_lo + CNT_W'(1);

  // One search level: descend left when the rank lies in the left subtree
  assign go_right = rank_q > tree_rdata;
  assign rank_d   = go_right ? rank_q - tree_rdata : rank_q;
  assign node_d   = {node_q[VALUE_BITS-1:0], go_right};

  // Node on the update path at the current level
  assign upd_shift = LVL_W'(VALUE_BITS) - upd_lvl_q;
  assign path_idx  = {1'b1, upd_val_q} >> upd_shift;

  // Tree port selection
  always_comb begin
    if (upd_act_q) begin
      tree_raddr = path_idx;
    end else if (cmd_i.srch_go) begin
      tree_raddr = NODE_AW'(2);
    end else begin
      tree_raddr = {node_d[VALUE_BITS-1:0], 1'b0};
    end
  end

  assign tree_we    = cmd_i.clr_run || wr_pend_q;
  assign tree_waddr = cmd_i.clr_run ? clr_q : wr_addr_q;
  assign tree_wdata = cmd_i.clr_run ? '0 :
                      (upd_dec_q ? tree_rdata - CNT_W'(1) : tree_rdata + CNT_W'(1));

  smsd_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TREE_DEPTH)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (tree_we),
    .waddr_i (tree_waddr),
    .wdata_i (tree_wdata),
    .raddr_i (tree_raddr),
    .rdata_o (tree_rdata)
  );

  smsd_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish),
    .waddr_i (ptr_q),
    .wdata_i (sample_q),
    .raddr_i (ptr_q),
    .rdata_o (ring_rdata)
  );

  // Doubled median and spike test
  always_comb begin
    if (!full_q) begin
      medd_val = '0;
    end else if (!eff_len[0]) begin
      medd_val = {1'b0, m1_q} + {1'b0, m2_q};
    end else begin
      medd_val = {m1_q, 1'b0};
    end
  end

  assign spike_now = full_q && ({1'b0, sample_q} >= medd_val);
  assign total_d   = (spike_now && (total_q != '1)) ? total_q + 32'd1 : total_q;
  assign ptr_inc   = CNT_W'(ptr_q) + CNT_W'(1);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg_q   <= smsd_pkg::LEN_RESET;
      ptr_q       <= '0;
      held_q      <= '0;
      total_q     <= '0;
      clr_q       <= '0;
      srch_act_q  <= 1'b0;
      srch_lvl_q  <= '0;
      upd_act_q   <= 1'b0;
      upd_lvl_q   <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Clearing pass, restarted by a length write
      if (cfg_we_i) begin
        clr_q <= '0;
      end else if (cmd_i.clr_run) begin
        clr_q <= clr_q + NODE_AW'(1);
      end
      // Search walk
      if (cmd_i.srch_go) begin
        srch_act_q <= 1'b1;
        srch_lvl_q <= '0;
      end else if (srch_act_q) begin
        srch_lvl_q <= srch_lvl_q + LVL_W'(1);
        if (sts_o.srch_last) begin
          srch_act_q <= 1'b0;
        end
      end
      // Update walk; the write follows its read in the next cycle
      wr_pend_q <= upd_act_q;
      if (cmd_i.upd_go) begin
        upd_act_q <= 1'b1;
        upd_lvl_q <= LVL_W'(1);
      end else if (upd_act_q) begin
        upd_lvl_q <= upd_lvl_q + LVL_W'(1);
        if (upd_lvl_q == LVL_W'(VALUE_BITS)) begin
          upd_act_q <= 1'b0;
        end
      end
      // Window bookkeeping
      if (cfg_we_i) begin
        len_reg_q <= cfg_len_i;
        ptr_q     <= '0;
        held_q    <= '0;
      end else if (cmd_i.finish) begin
        ptr_q <= (ptr_inc >= eff_len) ? '0 : ptr_inc[RING_AW-1:0];
        if (!full_q) begin
          held_q <= held_q + CNT_W'(1);
        end
        total_q <= total_d;
      end
      // Result register: hold until the transfer completes
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= VALUE_BITS'(sample_i);
      full_q   <= held_q >= eff_len;
    end
    if (cmd_i.load_old) begin
      old_q <= ring_rdata;
    end
    if (cmd_i.srch_go) begin
      node_q    <= NODE_AW'(1);
      rank_q    <= cmd_i.srch_lo ? rank_lo : rank_hi;
      srch_lo_q <= cmd_i.srch_lo;
    end else if (srch_act_q) begin
      node_q <= node_d;
      rank_q <= rank_d;
      if (sts_o.srch_last) begin
        if (srch_lo_q) begin
          m2_q <= node_d[VALUE_BITS-1:0];
        end else begin
          m1_q <= node_d[VALUE_BITS-1:0];
        end
      end
    end
    if (cmd_i.upd_go) begin
      upd_val_q <= cmd_i.upd_dec ? old_q : sample_q;
      upd_dec_q <= cmd_i.upd_dec;
    end
    if (upd_act_q) begin
      wr_addr_q <= path_idx;
    end
    if (cmd_i.finish) begin
      out_full_q  <= full_q;
      out_spike_q <= spike_now;
      out_medd_q  <= smsd_pkg::MEDD_W'(medd_val);
      out_count_q <= total_d;
    end
  end

  // Status
  assign sts_o.full      = full_q;
  assign sts_o.even      = !eff_len[0];
  assign sts_o.srch_last = srch_act_q && (srch_lvl_q == LVL_W'(VALUE_BITS - 1));
  assign sts_o.upd_busy  = upd_act_q || wr_pend_q;
  assign sts_o.clr_last  = clr_q == '1;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign window_full_o    = out_full_q;
  assign spike_o          = out_spike_q;
  assign median_doubled_o = out_medd_q;
  assign spike_count_o    = out_count_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_median_spike_detector.sv -----
// ----------------------------------------------------------------------------
// sliding_median_spike_detector: top level
// Samples enter on sample_ch, one result per sample leaves on result_ch.
// Once the window holds window_length samples, each new sample is tested
// against twice the window median and a saturating spike count is kept.
// Writing window_length (window_length_we_i) empties the window; the spike
// count is kept. Write it only while no sample is in flight.
// Per sample the block walks a count tree of VALUE_BITS levels through one
// read port: once the window is full, a rank search per middle value and a
// removal walk, then an insertion walk; while the window fills, only the
// insertion walk. The next sample is taken in the cycle after the result
// loads. After reset and after each length write a clearing pass zeroes
// the tree; sample_ch.ready stays low meanwhile.
// A result waits in the output register while result_ch stalls; the next
// sample is still taken and held at its final step until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_median_spike_detector #(
  parameter int unsigned VALUE_BITS = 8,
  parameter int unsigned WINDOW_MAX = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           window_length_we_i,
  input  wire logic [smsd_pkg::LEN_REG_W-1:0] window_length_i,
  smsd_sample_if.sink                         sample_ch,
  smsd_result_if.source                       result_ch
);

  smsd_pkg::cmd_t cmd;
  smsd_pkg::sts_t sts;
  logic           in_ready;

  assign sample_ch.ready = in_ready;

  smsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (window_length_we_i),
    .in_valid_i (sample_ch.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smsd_dp #(
    .VALUE_BITS (VALUE_BITS),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (window_length_we_i),
    .cfg_len_i        (window_length_i),
    .sample_i         (sample_ch.sample),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (result_ch.ready),
    .out_valid_o      (result_ch.valid),
    .window_full_o    (result_ch.window_full),
    .spike_o          (result_ch.spike),
    .median_doubled_o (result_ch.median_doubled),
    .spike_count_o    (result_ch.spike_count)
  );

`ifndef SYNTHESIS
  // A search never overlaps an update walk on the shared tree port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.srch_last && sts.upd_busy))
    else $error("search and update walk overlap");

  // The result register is loaded only when its previous result has left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!result_ch.valid || result_ch.ready))
    else $error("result overwritten before transfer");

  // After a sample transfer the block is busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
    else $error("second sample taken while busy");
`endif

endmodule

`default_nettype wire

// ----- tb/sliding_median_spike_detector_tb.sv -----
// ----------------------------------------------------------------------------
// sliding_median_spike_detector_tb: self-checking testbench
// Drives samples through the valid/ready sample channel and predicts each
// result with a local histogram-and-ring model of the trailing window. Every
// result transfer is compared field by field against the oldest prediction.
// Runs default, directed, random, backpressure, sender-pause and
// largest-window phases, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_median_spike_detector_tb;

  localparam int unsigned VALUE_BITS       = 8;
  localparam int unsigned NUM_VALUES       = 1 << VALUE_BITS;
  localparam int unsigned WINDOW_LIMIT     = 1024;
  localparam int unsigned SETTLE_CYCLES    = 48;     // above the even-window latency
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT      = 8000;
  localparam int unsigned RANDOM_ITEMS     = 300;
  localparam int unsigned LARGEST_ITEMS    = 40;
  localparam int unsigned RESET_CYCLES     = 8;

  typedef logic [smsd_pkg::SAMPLE_W-1:0]  sample_t;
  typedef logic [smsd_pkg::LEN_REG_W-1:0] length_t;

  typedef struct packed {
    logic                         window_full;
    logic                         spike;
    logic [smsd_pkg::MEDD_W-1:0]  median_doubled;
    logic [smsd_pkg::COUNT_W-1:0] spike_count;
  } spike_verdict_t;

  typedef enum logic [1:0] {
    PROFILE_UNIFORM,
    PROFILE_BAND,
    PROFILE_SPIKY,
    PROFILE_EDGES
  } sample_profile_e;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    window_length_we_i;
  length_t window_length_i;

  smsd_sample_if sample_ch ();
  smsd_result_if result_ch ();

  sliding_median_spike_detector #(
    .VALUE_BITS(VALUE_BITS),
    .WINDOW_MAX(WINDOW_LIMIT)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .window_length_we_i (window_length_we_i),
    .window_length_i    (window_length_i),
    .sample_ch          (sample_ch),
    .result_ch          (result_ch)
  );

  always #1 clk_i = ~clk_i;

  // Window model state
  int unsigned    value_tally [NUM_VALUES];
  sample_t        history [WINDOW_LIMIT];
  int unsigned    oldest_slot;
  int unsigned    held_count;
  length_t        length_setting;
  logic [31:0]    spike_tally;

  spike_verdict_t pending_verdicts [$];

  // Pacing controls shared by the tests and the result pacing process
  bit source_steady = 1'b0;
  bit sink_steady   = 1'b0;
  bit sink_hold_req = 1'b0;

  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned full_results    = 0;
  int unsigned spikes_seen     = 0;
  int unsigned length_writes   = 0;

  // --------------------------------------------------------------------------
  // Window model
  // --------------------------------------------------------------------------

  function automatic void empty_window_model();
    foreach (value_tally[v]) value_tally[v] = 0;
    oldest_slot = 0;
    held_count  = 0;
  endfunction

  function automatic int unsigned active_length();
    if (length_setting == '0) return 1;
    if (length_setting > WINDOW_LIMIT) return WINDOW_LIMIT;
    return length_setting;
  endfunction

  // Smallest value whose running count reaches the given 1-based rank
  function automatic int unsigned value_at_rank(input int unsigned rank);
    int unsigned running;
    running = 0;
    for (int v = 0; v < NUM_VALUES; v++) begin
      running += value_tally[v];
      if (running >= rank) return v;
    end
    return 0;
  endfunction

  function automatic void store_in_window(input sample_t value, input int unsigned len);
    history[oldest_slot] = value;
    value_tally[value]++;
    oldest_slot++;
    if (oldest_slot >= len) oldest_slot = 0;
  endfunction

  function automatic spike_verdict_t predict_spike_verdict(input sample_t value);
    spike_verdict_t verdict;
    int unsigned    len;
    int unsigned    twice;
    sample_t        leaving;
    verdict = '0;
    len     = active_length();
    if (held_count >= len) begin
      verdict.window_full = 1'b1;
      twice = value_at_rank(len / 2 + 1);
      if (len % 2 == 0) twice += value_at_rank(len / 2);
      else twice *= 2;
      verdict.median_doubled = twice[smsd_pkg::MEDD_W-1:0];
      if (value >= twice) begin
        verdict.spike = 1'b1;
        if (spike_tally != '1) spike_tally++;
      end
      // Drop the oldest sample, then take the new one into its slot
      leaving = history[oldest_slot];
      if (value_tally[leaving] > 0) value_tally[leaving]--;
      store_in_window(value, len);
    end else begin
      store_in_window(value, len);
      held_count++;
    end
    verdict.spike_count = spike_tally;
    return verdict;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 60);
  endfunction

  function automatic sample_t draw_sample(input sample_profile_e profile,
                                          input int unsigned base);
    int unsigned pick;
    case (profile)
      PROFILE_BAND: begin
        return sample_t'(base + $urandom_range(0, 20));
      end
      PROFILE_SPIKY: begin
        if ($urandom_range(0, 99) < 85) return sample_t'($urandom_range(0, 40));
        return sample_t'($urandom_range(80, 255));
      end
      PROFILE_EDGES: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd127;
          3: return 8'd128;
          4: return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: begin
        return sample_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Offer one sample and hold it until the transfer; valid stays high after
  task automatic send_sample(input sample_t value);
    int unsigned gap;
    gap = source_steady ? 0 : pick_gap();
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk_i); while (!sample_ch.ready);
    pending_verdicts.push_back(predict_spike_verdict(value));
  endtask

  task automatic end_burst();
    sample_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_values(input int unsigned values[$]);
    foreach (values[i]) send_sample(sample_t'(values[i]));
    end_burst();
  endtask

  task automatic send_series(input int unsigned count, input sample_profile_e profile);
    int unsigned base;
    base = $urandom_range(0, 235);
    repeat (count) send_sample(draw_sample(profile, base));
    end_burst();
  endtask

  // Write the window length once the block has gone quiet
  task automatic write_window_length(input length_t value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    window_length_we_i <= 1'b1;
    window_length_i    <= value;
    @(posedge clk_i);
    window_length_we_i <= 1'b0;
    length_setting = value;
    empty_window_model();
    length_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Run on the reset window length with no register write
  task automatic test_default_length();
    send_series(64, PROFILE_SPIKY);
  endtask

  // Short windows with hand-picked samples: zero length acting as one,
  // equality at the threshold, even-window means, extremes of the sample
  task automatic test_directed_cases();
    write_window_length('0);
    send_values('{255, 0, 0, 128, 127, 128});
    write_window_length(11'd1);
    send_values('{200, 100, 200});
    write_window_length(11'd2);
    send_values('{10, 21, 31, 0, 255});
    write_window_length(11'd3);
    send_values('{5, 250, 7, 14, 13});
    write_window_length(11'd4);
    send_values('{255, 255, 255, 255, 255});
  endtask

  // Random window lengths, mostly small, with random sample profiles
  task automatic test_random_windows();
    int unsigned     sent;
    int unsigned     len;
    int unsigned     count;
    int unsigned     roll;
    sample_profile_e profile;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) len = $urandom_range(1, 16);
      else if (roll < 95) len = $urandom_range(17, 80);
      else len = $urandom_range(81, 200);
      write_window_length(length_t'(len));
      profile       = sample_profile_e'($urandom_range(0, 3));
      count         = len + $urandom_range(8, 30);
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      send_series(count, profile);
      sent += count;
    end
    source_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  // Hold the result side off for a long stretch while samples keep coming
  task automatic test_output_backpressure();
    write_window_length(11'd7);
    // Wait out the clearing pass so the hold lands on live traffic
    while (!sample_ch.ready) @(posedge clk_i);
    source_steady = 1'b1;
    sink_hold_req = 1'b1;
    send_series(24, PROFILE_SPIKY);
    source_steady = 1'b0;
    wait_drain();
  endtask

  // Let the block drain completely between bursts on the same window
  task automatic test_sender_pause();
    write_window_length(11'd6);
    repeat (3) begin
      send_series(8, PROFILE_UNIFORM);
      wait_drain();
    end
  endtask

  // Oversized length clamps to the largest window, which stays filling here
  task automatic test_largest_window();
    write_window_length('1);
    send_series(LARGEST_ITEMS, PROFILE_SPIKY);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Randomly stall the result channel; honor a long hold when asked
  initial begin : result_pacing
    int unsigned stall;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
        sink_hold_req = 1'b0;
      end else begin
        stall = sink_steady ? 0 : pick_gap();
        if (stall == 0) begin
          result_ch.ready <= 1'b1;
        end else begin
          result_ch.ready <= 1'b0;
          repeat (stall - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Compare every result transfer with the oldest prediction
  always @(posedge clk_i) begin : result_check
    spike_verdict_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t ns: result transfer with no prediction pending", $time);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("window_full", want.window_full, result_ch.window_full);
        compare_field("spike", want.spike, result_ch.spike);
        compare_field("median_doubled", want.median_doubled, result_ch.median_doubled);
        compare_field("spike_count", want.spike_count, result_ch.spike_count);
        results_checked++;
        if (want.window_full) full_results++;
        if (want.spike) spikes_seen++;
      end
    end
  end

  // Abort when no transfer happens on either channel for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t ns: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin : main_sequence
    rst_ni             <= 1'b0;
    window_length_we_i <= 1'b0;
    window_length_i    <= smsd_pkg::LEN_RESET;
    sample_ch.valid    <= 1'b0;
    sample_ch.sample   <= '0;
    length_setting = smsd_pkg::LEN_RESET;
    spike_tally    = '0;
    empty_window_model();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_length();
    test_directed_cases();
    test_random_windows();
    test_output_backpressure();
    test_sender_pause();
    test_largest_window();

    // Drain, then watch a little longer for stray results
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d results over %0d window length writes: %0d full-window tests, %0d spikes",
             results_checked, length_writes, full_results, spikes_seen);
    $display("Covered zero and oversized lengths, odd and even windows, long output stall");
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_verdicts.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
